>>> hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated off while reset is asserted.
`define STT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, gated off while reset is asserted.
`define STT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> hw/rtl/stt_pkg.sv
`timescale 1ns / 1ps

package stt_pkg;

  // Token kinds as they appear on the result channel
  typedef enum logic [4:0] {
    KIND_IDENT    = 5'd0,
    KIND_VAR      = 5'd1,
    KIND_IF       = 5'd2,
    KIND_WHILE    = 5'd3,
    KIND_PRINTENV = 5'd4,
    KIND_END      = 5'd5,
    KIND_NUMBER   = 5'd6,
    KIND_STRING   = 5'd7,
    KIND_ASSIGN   = 5'd8,
    KIND_EQEQ     = 5'd9,
    KIND_SEMI     = 5'd10,
    KIND_PLUS     = 5'd11,
    KIND_MINUS    = 5'd12,
    KIND_STAR     = 5'd13,
    KIND_SLASH    = 5'd14,
    KIND_LESS     = 5'd15,
    KIND_GREATER  = 5'd16,
    KIND_LBRACE   = 5'd17,
    KIND_RBRACE   = 5'd18,
    KIND_EOF      = 5'd19,
    KIND_ERROR    = 5'd20
  } tok_kind_e;

  // Cause code carried by error tokens
  typedef enum logic [1:0] {
    CAUSE_NONE         = 2'd0,
    CAUSE_UNEXPECTED   = 2'd1,
    CAUSE_UNTERMINATED = 2'd2
  } cause_e;

  // One finished token, minus the end-of-run flag
  typedef struct packed {
    tok_kind_e   kind;
    cause_e      cause;
    logic [31:0] start;
    logic [31:0] length;
    logic [31:0] line;
  } token_t;

endpackage

>>> hw/rtl/stt_ifs.sv
`timescale 1ns / 1ps

// Source byte channel
interface stt_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, char_code, end_of_text, input ready);
  modport sink (input valid, char_code, end_of_text, output ready);
endinterface

// Token channel
interface stt_token_if;
  logic               valid;
  logic               ready;
  stt_pkg::tok_kind_e token_kind;
  stt_pkg::cause_e    error_cause;
  logic [31:0]        start_offset;
  logic [31:0]        token_length;
  logic [31:0]        line_number;
  logic               last_of_run;

  modport source (output valid, token_kind, error_cause, start_offset, token_length,
                  line_number, last_of_run, input ready);
  modport sink (input valid, token_kind, error_cause, start_offset, token_length,
                line_number, last_of_run, output ready);
endinterface

>>> hw/rtl/source_text_tokenizer_top.sv
`timescale 1ns / 1ps

// Source text tokenizer.
// char_i takes one source byte per transaction, or an end-of-text mark
// (end_of_text high, char_code ignored). token_o delivers one token per
// transaction; last_of_run marks the final token caused by one input item.
// An item produces zero to three tokens; end of text always ends with EOF.
// A byte is held in the input register; its tokens go to the token buffer.
// Throughput: one item per cycle while token_o is ready and each item
// yields at most one token. The three-slot token buffer drains one token
// per cycle on token_o while it is ready; an item with several tokens
// holds the input off until its last token is being taken. A stalled
// token_o fills the byte register and then drops char_i.ready; nothing is
// lost. After EOF the scanner state returns to its reset values.
// Reset: mode idle, offset 0, line 1, buffers empty; ready rises at once.
// Offsets wrap at OFFSET_BITS; line counter saturates at LINE_BITS.
module source_text_tokenizer_top #(
  parameter int OFFSET_BITS = 32,
  parameter int LINE_BITS   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  stt_char_if.sink    char_i,
  stt_token_if.source token_o
);

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_SLASH,
    MODE_COMMENT,
    MODE_EQ,
    MODE_WORD,
    MODE_INT,
    MODE_DOT,
    MODE_FRAC,
    MODE_STRING
  } mode_e;

  // Keywords, first byte in the low bits, zero padded
  localparam logic [63:0] KW_VAR      = 64'h0000_0000_0072_6176;
  localparam logic [63:0] KW_IF       = 64'h0000_0000_0000_6669;
  localparam logic [63:0] KW_WHILE    = 64'h0000_0065_6C69_6877;
  localparam logic [63:0] KW_PRINTENV = 64'h766E_6574_6E69_7270;
  localparam logic [63:0] KW_END      = 64'h0000_0000_0064_6E65;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQUAL = 8'h3D;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           (c == 8'h5F);
  endfunction

  function automatic stt_pkg::tok_kind_e word_kind(logic [63:0] prefix, logic [3:0] len);
    stt_pkg::tok_kind_e k;
    k = stt_pkg::KIND_IDENT;
    if (len == 4'd3 && prefix == KW_VAR) k = stt_pkg::KIND_VAR;
    else if (len == 4'd2 && prefix == KW_IF) k = stt_pkg::KIND_IF;
    else if (len == 4'd5 && prefix == KW_WHILE) k = stt_pkg::KIND_WHILE;
    else if (len == 4'd8 && prefix == KW_PRINTENV) k = stt_pkg::KIND_PRINTENV;
    else if (len == 4'd3 && prefix == KW_END) k = stt_pkg::KIND_END;
    return k;
  endfunction

  function automatic stt_pkg::token_t mk_tok(stt_pkg::tok_kind_e kind, stt_pkg::cause_e cause,
                                             logic [OFFSET_BITS-1:0] start,
                                             logic [OFFSET_BITS-1:0] len,
                                             logic [LINE_BITS-1:0] line);
    stt_pkg::token_t t;
    t.kind   = kind;
    t.cause  = cause;
    t.start  = 32'(start);
    t.length = 32'(len);
    t.line   = 32'(line);
    return t;
  endfunction

  // Input register
  logic       inq_valid_q;
  logic [7:0] inq_char_q;
  logic       inq_eot_q;

  // Scanner state
  mode_e                  mode_q, mode_d;
  logic [OFFSET_BITS-1:0] off_q, off_d;
  logic [OFFSET_BITS-1:0] origin_q, origin_d;
  logic [LINE_BITS-1:0]   line_q, line_d;
  logic [63:0]            prefix_q, prefix_d;
  logic [3:0]             wlen_q, wlen_d;

  // Token buffer
  stt_pkg::token_t bank_q [3];
  logic [1:0]      cnt_q, idx_q;

  logic                   proc_fire, bank_free, out_fire;
  logic [OFFSET_BITS-1:0] span, prev;
  logic [LINE_BITS-1:0]   line_inc;
  logic [7:0]             c;

  // Lookup from the idle mode
  mode_e           idle_mode;
  logic            idle_nl, idle_word, idle_emit;
  stt_pkg::token_t idle_tok;

  // Tokens of this item: up to two pending, then one from idle or EOF
  logic            emit_a, emit_b, emit_c;
  stt_pkg::token_t tok_a, tok_b, tok_c;
  stt_pkg::token_t res_d [3];
  logic [1:0]      res_n;
  logic            redo;

  assign c        = inq_char_q;
  assign span     = off_q - origin_q;
  assign prev     = off_q - OFFSET_BITS'(1);
  assign line_inc = (line_q == '1) ? line_q : line_q + LINE_BITS'(1);

  // Handshakes
  assign out_fire     = token_o.valid && token_o.ready;
  assign bank_free    = (idx_q == cnt_q) || ((idx_q + 2'd1 == cnt_q) && token_o.ready);
  assign proc_fire    = inq_valid_q && bank_free;
  assign char_i.ready = !inq_valid_q || proc_fire;

  // Scan of one byte from the idle mode
  always_comb begin
    idle_mode = MODE_IDLE;
    idle_nl   = 1'b0;
    idle_word = 1'b0;
    idle_emit = 1'b0;
    idle_tok  = mk_tok(stt_pkg::KIND_ERROR, stt_pkg::CAUSE_UNEXPECTED, off_q,
                       OFFSET_BITS'(1), '0);
    if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
      idle_mode = MODE_IDLE;
    end else if (c == CH_LF) begin
      idle_nl = 1'b1;
    end else if (c == CH_SLASH) begin
      idle_mode = MODE_SLASH;
    end else if (c == CH_EQUAL) begin
      idle_mode = MODE_EQ;
    end else if (c == CH_QUOTE) begin
      idle_mode = MODE_STRING;
    end else if (is_alpha(c)) begin
      idle_mode = MODE_WORD;
      idle_word = 1'b1;
    end else if (is_digit(c)) begin
      idle_mode = MODE_INT;
    end else begin
      idle_emit = 1'b1;
      case (c)
        8'h3B: idle_tok.kind = stt_pkg::KIND_SEMI;
        8'h2B: idle_tok.kind = stt_pkg::KIND_PLUS;
        8'h2D: idle_tok.kind = stt_pkg::KIND_MINUS;
        8'h2A: idle_tok.kind = stt_pkg::KIND_STAR;
        8'h3C: idle_tok.kind = stt_pkg::KIND_LESS;
        8'h3E: idle_tok.kind = stt_pkg::KIND_GREATER;
        8'h7B: idle_tok.kind = stt_pkg::KIND_LBRACE;
        8'h7D: idle_tok.kind = stt_pkg::KIND_RBRACE;
        default: idle_tok.kind = stt_pkg::KIND_ERROR;
      endcase
      if (idle_tok.kind != stt_pkg::KIND_ERROR) begin
        idle_tok.cause = stt_pkg::CAUSE_NONE;
        idle_tok.line  = 32'(line_q);
      end
    end
  end

  // Mode transition and token generation
  always_comb begin
    mode_d   = mode_q;
    off_d    = off_q + OFFSET_BITS'(1);
    origin_d = origin_q;
    line_d   = line_q;
    prefix_d = prefix_q;
    wlen_d   = wlen_q;
    redo     = 1'b0;
    emit_a   = 1'b0;
    emit_b   = 1'b0;
    emit_c   = 1'b0;
    tok_a    = mk_tok(stt_pkg::KIND_NUMBER, stt_pkg::CAUSE_NONE, origin_q, span, line_q);
    tok_b    = mk_tok(stt_pkg::KIND_ERROR, stt_pkg::CAUSE_UNEXPECTED, prev,
                      OFFSET_BITS'(1), '0);
    tok_c    = idle_tok;

    if (inq_eot_q) begin
      // Flush the pending token, then EOF and back to reset values
      unique case (mode_q)
        MODE_WORD: begin
          emit_a     = 1'b1;
          tok_a.kind = word_kind(prefix_q, wlen_q);
        end
        MODE_INT, MODE_FRAC: emit_a = 1'b1;
        MODE_DOT: begin
          emit_a       = 1'b1;
          emit_b       = 1'b1;
          tok_a.length = 32'(span - OFFSET_BITS'(1));
        end
        MODE_SLASH: begin
          emit_a = 1'b1;
          tok_a  = mk_tok(stt_pkg::KIND_SLASH, stt_pkg::CAUSE_NONE, origin_q,
                          OFFSET_BITS'(1), line_q);
        end
        MODE_EQ: begin
          emit_a = 1'b1;
          tok_a  = mk_tok(stt_pkg::KIND_ASSIGN, stt_pkg::CAUSE_NONE, origin_q,
                          OFFSET_BITS'(1), line_q);
        end
        MODE_STRING: begin
          emit_a = 1'b1;
          tok_a  = mk_tok(stt_pkg::KIND_ERROR, stt_pkg::CAUSE_UNTERMINATED, origin_q,
                          span, '0);
        end
        default: ;
      endcase
      emit_c   = 1'b1;
      tok_c    = mk_tok(stt_pkg::KIND_EOF, stt_pkg::CAUSE_NONE, off_q, '0, line_q);
      mode_d   = MODE_IDLE;
      off_d    = '0;
      origin_d = '0;
      line_d   = LINE_BITS'(1);
      prefix_d = '0;
      wlen_d   = '0;
    end else begin
      unique case (mode_q)
        MODE_COMMENT: begin
          if (c == CH_LF) begin
            mode_d = MODE_IDLE;
            line_d = line_inc;
          end
        end
        MODE_SLASH: begin
          if (c == CH_SLASH) begin
            mode_d = MODE_COMMENT;
          end else begin
            emit_a = 1'b1;
            tok_a  = mk_tok(stt_pkg::KIND_SLASH, stt_pkg::CAUSE_NONE, origin_q,
                            OFFSET_BITS'(1), line_q);
            redo   = 1'b1;
          end
        end
        MODE_EQ: begin
          emit_a = 1'b1;
          if (c == CH_EQUAL) begin
            tok_a  = mk_tok(stt_pkg::KIND_EQEQ, stt_pkg::CAUSE_NONE, origin_q,
                            OFFSET_BITS'(2), line_q);
            mode_d = MODE_IDLE;
          end else begin
            tok_a = mk_tok(stt_pkg::KIND_ASSIGN, stt_pkg::CAUSE_NONE, origin_q,
                           OFFSET_BITS'(1), line_q);
            redo  = 1'b1;
          end
        end
        MODE_WORD: begin
          if (is_alpha(c) || is_digit(c)) begin
            // Keep the first eight bytes, count up to nine
            for (int i = 0; i < 8; i++) begin
              if (wlen_q == 4'(i)) prefix_d[8*i +: 8] = c;
            end
            if (wlen_q < 4'd9) wlen_d = wlen_q + 4'd1;
          end else begin
            emit_a     = 1'b1;
            tok_a.kind = word_kind(prefix_q, wlen_q);
            redo       = 1'b1;
          end
        end
        MODE_INT: begin
          if (c == CH_DOT) begin
            mode_d = MODE_DOT;
          end else if (!is_digit(c)) begin
            emit_a = 1'b1;
            redo   = 1'b1;
          end
        end
        MODE_DOT: begin
          if (is_digit(c)) begin
            mode_d = MODE_FRAC;
          end else begin
            // Number without the dot, then an error for the dot
            emit_a       = 1'b1;
            emit_b       = 1'b1;
            tok_a.length = 32'(span - OFFSET_BITS'(1));
            redo         = 1'b1;
          end
        end
        MODE_FRAC: begin
          if (!is_digit(c)) begin
            emit_a = 1'b1;
            redo   = 1'b1;
          end
        end
        MODE_STRING: begin
          if (c == CH_QUOTE) begin
            emit_a = 1'b1;
            tok_a  = mk_tok(stt_pkg::KIND_STRING, stt_pkg::CAUSE_NONE, origin_q,
                            span + OFFSET_BITS'(1), line_q);
            mode_d = MODE_IDLE;
          end else if (c == CH_LF) begin
            line_d = line_inc;
          end
        end
        default: redo = 1'b1;
      endcase

      // Rescan the current byte from idle
      if (redo) begin
        mode_d   = idle_mode;
        origin_d = off_q;
        emit_c   = idle_emit;
        if (idle_nl) line_d = line_inc;
        if (idle_word) begin
          prefix_d = 64'(c);
          wlen_d   = 4'd1;
        end
      end
    end
  end

  // Pack the tokens of this item into consecutive slots
  always_comb begin
    res_d[0] = tok_a;
    res_d[1] = tok_b;
    res_d[2] = tok_c;
    if (!emit_a) res_d[0] = tok_c;
    else if (!emit_b) res_d[1] = tok_c;
    res_n = 2'(emit_a) + 2'(emit_b) + 2'(emit_c);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
      mode_q      <= MODE_IDLE;
      off_q       <= '0;
      origin_q    <= '0;
      line_q      <= LINE_BITS'(1);
      prefix_q    <= '0;
      wlen_q      <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
    end else begin
      if (char_i.ready) inq_valid_q <= char_i.valid;
      if (proc_fire) begin
        mode_q   <= mode_d;
        off_q    <= off_d;
        origin_q <= origin_d;
        line_q   <= line_d;
        prefix_q <= prefix_d;
        wlen_q   <= wlen_d;
        cnt_q    <= res_n;
        idx_q    <= '0;
      end else if (out_fire) begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (char_i.valid && char_i.ready) begin
      inq_char_q <= char_i.char_code;
      inq_eot_q  <= char_i.end_of_text;
    end
    if (proc_fire) begin
      bank_q[0] <= res_d[0];
      bank_q[1] <= res_d[1];
      bank_q[2] <= res_d[2];
    end
  end

  // Token output
  stt_pkg::token_t out_tok;

  always_comb begin
    case (idx_q)
      2'd1:    out_tok = bank_q[1];
      2'd2:    out_tok = bank_q[2];
      default: out_tok = bank_q[0];
    endcase
  end

  assign token_o.valid        = (idx_q != cnt_q);
  assign token_o.token_kind   = out_tok.kind;
  assign token_o.error_cause  = out_tok.cause;
  assign token_o.start_offset = out_tok.start;
  assign token_o.token_length = out_tok.length;
  assign token_o.line_number  = out_tok.line;
  assign token_o.last_of_run  = (idx_q + 2'd1 == cnt_q);

endmodule

>>> hw/rtl/stt_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        tok_valid_i,
  input logic        tok_ready_i,
  input logic [4:0]  tok_kind_i,
  input logic [1:0]  tok_cause_i,
  input logic [31:0] tok_length_i,
  input logic [31:0] tok_line_i,
  input logic        tok_last_i
);

  logic is_err, is_eof;

  assign is_err = tok_valid_i && (tok_kind_i == stt_pkg::KIND_ERROR);
  assign is_eof = tok_valid_i && (tok_kind_i == stt_pkg::KIND_EOF);

  // A stalled token stays offered
  `STT_ASSERT_NXT(a_tok_hold, clk_i, rst_ni, tok_valid_i && !tok_ready_i, tok_valid_i)

  // EOF closes its run and has no length
  `STT_ASSERT_IMP(a_eof_last, clk_i, rst_ni, is_eof, tok_last_i && tok_length_i == '0)

  // Error tokens carry a cause and report line zero
  `STT_ASSERT_IMP(a_err_fields, clk_i, rst_ni, is_err,
                  tok_cause_i != stt_pkg::CAUSE_NONE && tok_line_i == '0)

  // Other tokens carry no cause
  `STT_ASSERT_IMP(a_no_cause, clk_i, rst_ni, tok_valid_i && !is_err,
                  tok_cause_i == stt_pkg::CAUSE_NONE)

endmodule

bind source_text_tokenizer_top stt_checker u_stt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .tok_valid_i  (token_o.valid),
  .tok_ready_i  (token_o.ready),
  .tok_kind_i   (token_o.token_kind),
  .tok_cause_i  (token_o.error_cause),
  .tok_length_i (token_o.token_length),
  .tok_line_i   (token_o.line_number),
  .tok_last_i   (token_o.last_of_run)
);

>>> dv/source_text_tokenizer_top_test.sv
`timescale 1ns / 1ps

module source_text_tokenizer_top_test;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASES = 5;

  // Scanner modes of the token predictor
  typedef enum logic [3:0] {
    LM_IDLE, LM_SLASH, LM_COMMENT, LM_EQ, LM_WORD, LM_INT, LM_DOT, LM_FRAC, LM_STRING
  } lex_mode_e;

  typedef struct {
    logic [7:0] ch;
    logic       eot;
  } byte_item_t;

  typedef struct {
    stt_pkg::token_t tok;
    logic            last;
  } token_exp_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  stt_char_if  char_if ();
  stt_token_if tok_if ();

  source_text_tokenizer_top u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .char_i  (char_if),
    .token_o (tok_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  byte_item_t feed_q[$];
  token_exp_t token_q[$];
  token_exp_t run_q[$];
  int         pushed_cnt = 0;
  int         err_cnt = 0;
  int         cycle_cnt = 0;
  int         src_idle_pct = 0;
  int         sink_stall_pct = 0;
  logic       byte_taken = 1'b0;

  // Predictor state
  lex_mode_e   mode;
  logic [31:0] pos;
  logic [31:0] tok_start;
  logic [31:0] line_cnt;
  logic [63:0] word_bytes;
  logic [3:0]  word_len;

  string kw_list[5] = '{"var", "if", "while", "printenv", "end"};
  string near_kw[12] = '{"variable", "iff", "whilst", "printenvx", "ends", "en",
                         "i", "va", "print", "END", "If", "_end"};
  string op_list[11] = '{"=", "==", ";", "+", "-", "*", "/", "<", ">", "{", "}"};

  // ---------------------------------------------------------------- predictor

  task automatic lexer_reset();
    mode       = LM_IDLE;
    pos        = '0;
    tok_start  = '0;
    line_cnt   = 32'd1;
    word_bytes = '0;
    word_len   = '0;
  endtask

  task automatic bump_line();
    if (line_cnt != '1) line_cnt++;
  endtask

  task automatic add_tok(stt_pkg::tok_kind_e k, stt_pkg::cause_e c, logic [31:0] s,
                         logic [31:0] l, logic [31:0] ln);
    token_exp_t t;
    t.tok.kind   = k;
    t.tok.cause  = c;
    t.tok.start  = s;
    t.tok.length = l;
    t.tok.line   = ln;
    t.last       = 1'b0;
    run_q.push_back(t);
  endtask

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // Keywords match only at their exact length; bytes sit little-endian
  function automatic stt_pkg::tok_kind_e word_kind();
    if (word_len == 4'd3 && word_bytes[23:0] == {"r", "a", "v"}) return stt_pkg::KIND_VAR;
    if (word_len == 4'd2 && word_bytes[15:0] == {"f", "i"}) return stt_pkg::KIND_IF;
    if (word_len == 4'd5 && word_bytes[39:0] == {"e", "l", "i", "h", "w"})
      return stt_pkg::KIND_WHILE;
    if (word_len == 4'd8 && word_bytes == {"v", "n", "e", "t", "n", "i", "r", "p"})
      return stt_pkg::KIND_PRINTENV;
    if (word_len == 4'd3 && word_bytes[23:0] == {"d", "n", "e"}) return stt_pkg::KIND_END;
    return stt_pkg::KIND_IDENT;
  endfunction

  // Start a fresh token from idle with byte c at offset pos
  task automatic scan_fresh(logic [7:0] c);
    mode      = LM_IDLE;
    tok_start = pos;
    case (c)
      " ", "\t", "\r": ;
      "\n": bump_line();
      "/": mode = LM_SLASH;
      "=": mode = LM_EQ;
      "\"": mode = LM_STRING;
      ";": add_tok(stt_pkg::KIND_SEMI, stt_pkg::CAUSE_NONE, pos, 32'd1, line_cnt);
      "+": add_tok(stt_pkg::KIND_PLUS, stt_pkg::CAUSE_NONE, pos, 32'd1, line_cnt);
      "-": add_tok(stt_pkg::KIND_MINUS, stt_pkg::CAUSE_NONE, pos, 32'd1, line_cnt);
      "*": add_tok(stt_pkg::KIND_STAR, stt_pkg::CAUSE_NONE, pos, 32'd1, line_cnt);
      "<": add_tok(stt_pkg::KIND_LESS, stt_pkg::CAUSE_NONE, pos, 32'd1, line_cnt);
      ">": add_tok(stt_pkg::KIND_GREATER, stt_pkg::CAUSE_NONE, pos, 32'd1, line_cnt);
      "{": add_tok(stt_pkg::KIND_LBRACE, stt_pkg::CAUSE_NONE, pos, 32'd1, line_cnt);
      "}": add_tok(stt_pkg::KIND_RBRACE, stt_pkg::CAUSE_NONE, pos, 32'd1, line_cnt);
      default: begin
        if (is_alpha(c)) begin
          mode       = LM_WORD;
          word_bytes = {56'd0, c};
          word_len   = 4'd1;
        end else if (is_digit(c)) begin
          mode = LM_INT;
        end else begin
          add_tok(stt_pkg::KIND_ERROR, stt_pkg::CAUSE_UNEXPECTED, pos, 32'd1, 32'd0);
        end
      end
    endcase
  endtask

  // Work out the tokens caused by one accepted transaction
  task automatic lex_item(logic [7:0] c, logic eot);
    logic [31:0] span;
    logic [31:0] prev;
    logic        redo;
    run_q.delete();
    span = pos - tok_start;
    prev = pos - 32'd1;
    redo = 1'b0;
    if (eot) begin
      case (mode)
        LM_WORD: add_tok(word_kind(), stt_pkg::CAUSE_NONE, tok_start, span, line_cnt);
        LM_INT, LM_FRAC:
          add_tok(stt_pkg::KIND_NUMBER, stt_pkg::CAUSE_NONE, tok_start, span, line_cnt);
        LM_DOT: begin
          add_tok(stt_pkg::KIND_NUMBER, stt_pkg::CAUSE_NONE, tok_start, span - 32'd1,
                  line_cnt);
          add_tok(stt_pkg::KIND_ERROR, stt_pkg::CAUSE_UNEXPECTED, prev, 32'd1, 32'd0);
        end
        LM_SLASH:
          add_tok(stt_pkg::KIND_SLASH, stt_pkg::CAUSE_NONE, tok_start, 32'd1, line_cnt);
        LM_EQ:
          add_tok(stt_pkg::KIND_ASSIGN, stt_pkg::CAUSE_NONE, tok_start, 32'd1, line_cnt);
        LM_STRING:
          add_tok(stt_pkg::KIND_ERROR, stt_pkg::CAUSE_UNTERMINATED, tok_start, span, 32'd0);
        default: ;
      endcase
      add_tok(stt_pkg::KIND_EOF, stt_pkg::CAUSE_NONE, pos, 32'd0, line_cnt);
      lexer_reset();
    end else begin
      case (mode)
        LM_COMMENT: begin
          if (c == "\n") begin
            mode = LM_IDLE;
            bump_line();
          end
        end
        LM_SLASH: begin
          if (c == "/") begin
            mode = LM_COMMENT;
          end else begin
            add_tok(stt_pkg::KIND_SLASH, stt_pkg::CAUSE_NONE, tok_start, 32'd1, line_cnt);
            redo = 1'b1;
          end
        end
        LM_EQ: begin
          if (c == "=") begin
            add_tok(stt_pkg::KIND_EQEQ, stt_pkg::CAUSE_NONE, tok_start, 32'd2, line_cnt);
            mode = LM_IDLE;
          end else begin
            add_tok(stt_pkg::KIND_ASSIGN, stt_pkg::CAUSE_NONE, tok_start, 32'd1, line_cnt);
            redo = 1'b1;
          end
        end
        LM_WORD: begin
          if (is_alpha(c) || is_digit(c)) begin
            if (word_len < 4'd8) word_bytes[word_len*8 +: 8] = c;
            if (word_len < 4'd9) word_len++;
          end else begin
            add_tok(word_kind(), stt_pkg::CAUSE_NONE, tok_start, span, line_cnt);
            redo = 1'b1;
          end
        end
        LM_INT: begin
          if (c == ".") begin
            mode = LM_DOT;
          end else if (!is_digit(c)) begin
            add_tok(stt_pkg::KIND_NUMBER, stt_pkg::CAUSE_NONE, tok_start, span, line_cnt);
            redo = 1'b1;
          end
        end
        LM_DOT: begin
          if (is_digit(c)) begin
            mode = LM_FRAC;
          end else begin
            // number without its dot, then the dot alone as an error
            add_tok(stt_pkg::KIND_NUMBER, stt_pkg::CAUSE_NONE, tok_start, span - 32'd1,
                    line_cnt);
            add_tok(stt_pkg::KIND_ERROR, stt_pkg::CAUSE_UNEXPECTED, prev, 32'd1, 32'd0);
            redo = 1'b1;
          end
        end
        LM_FRAC: begin
          if (!is_digit(c)) begin
            add_tok(stt_pkg::KIND_NUMBER, stt_pkg::CAUSE_NONE, tok_start, span, line_cnt);
            redo = 1'b1;
          end
        end
        LM_STRING: begin
          if (c == "\"") begin
            add_tok(stt_pkg::KIND_STRING, stt_pkg::CAUSE_NONE, tok_start, span + 32'd1,
                    line_cnt);
            mode = LM_IDLE;
          end else if (c == "\n") begin
            bump_line();
          end
        end
        default: redo = 1'b1;
      endcase
      if (redo) scan_fresh(c);
      pos = pos + 32'd1;
    end
    if (run_q.size() > 0) run_q[run_q.size()-1].last = 1'b1;
    foreach (run_q[i]) token_q.push_back(run_q[i]);
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic push_byte(logic [7:0] c);
    byte_item_t it;
    it.ch  = c;
    it.eot = 1'b0;
    feed_q.push_back(it);
    pushed_cnt++;
  endtask

  task automatic push_eot();
    byte_item_t it;
    it.ch  = 8'($urandom_range(0, 255));
    it.eot = 1'b1;
    feed_q.push_back(it);
    pushed_cnt++;
  endtask

  task automatic push_str(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic [7:0] rand_alpha();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'("a") + 8'(r);
    if (r < 52) return 8'("A") + 8'(r - 26);
    return "_";
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0") + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 3))
      0: return " ";
      1: return "\t";
      2: return "\r";
      default: return "\n";
    endcase
  endfunction

  // Mostly well-formed source fragments, some glued together, some noise
  task automatic gen_text(int n_items);
    int goal;
    int pick;
    logic [7:0] sc;
    goal = pushed_cnt + n_items;
    while (pushed_cnt < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        push_str(kw_list[$urandom_range(0, 4)]);
      end else if (pick < 20) begin
        push_str(near_kw[$urandom_range(0, 11)]);
      end else if (pick < 32) begin
        push_byte(rand_alpha());
        repeat ($urandom_range(0, 10))
          push_byte(($urandom_range(0, 3) == 0) ? rand_digit() : rand_alpha());
      end else if (pick < 45) begin
        repeat ($urandom_range(1, 4)) push_byte(rand_digit());
        case ($urandom_range(0, 2))
          1: begin
            push_byte(".");
            repeat ($urandom_range(1, 3)) push_byte(rand_digit());
          end
          2: push_byte(".");
          default: ;
        endcase
      end else if (pick < 54) begin
        push_byte("\"");
        repeat ($urandom_range(0, 6)) begin
          sc = 8'($urandom_range(32, 126));
          if ($urandom_range(0, 9) == 0) sc = "\n";
          push_byte((sc == "\"") ? 8'("q") : sc);
        end
        // occasionally left open
        if ($urandom_range(0, 9) != 0) push_byte("\"");
      end else if (pick < 69) begin
        push_str(op_list[$urandom_range(0, 10)]);
      end else if (pick < 74) begin
        push_str("//");
        repeat ($urandom_range(0, 8)) push_byte(8'($urandom_range(0, 255)));
        push_byte("\n");
      end else if (pick < 89) begin
        push_byte(rand_blank());
      end else if (pick < 95) begin
        push_byte(8'($urandom_range(0, 255)));
      end else begin
        push_eot();
      end
      if ($urandom_range(0, 1) == 0) push_byte(($urandom_range(0, 3) == 0) ? 8'("\n") : 8'(" "));
    end
    push_eot();
  endtask

  // ---------------------------------------------------------------- driver

  always @(negedge clk_i) begin
    byte_item_t nxt;
    if (!rst_ni) begin
      char_if.valid <= 1'b0;
      tok_if.ready  <= 1'b0;
    end else begin
      if (!char_if.valid || byte_taken) begin
        if (feed_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          nxt = feed_q.pop_front();
          char_if.valid       <= 1'b1;
          char_if.char_code   <= nxt.ch;
          char_if.end_of_text <= nxt.eot;
        end else begin
          char_if.valid <= 1'b0;
        end
      end
      tok_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    token_exp_t want;
    if (!rst_ni) begin
      byte_taken = 1'b0;
    end else begin
      byte_taken = char_if.valid && char_if.ready;
      if (byte_taken) lex_item(char_if.char_code, char_if.end_of_text);
      if (tok_if.valid && tok_if.ready) begin
        if (token_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected token transaction: expected none, got kind %0d",
                   $time, tok_if.token_kind);
        end else begin
          want = token_q.pop_front();
          check_field("token_kind", 32'(tok_if.token_kind), 32'(want.tok.kind));
          check_field("error_cause", 32'(tok_if.error_cause), 32'(want.tok.cause));
          check_field("start_offset", tok_if.start_offset, want.tok.start);
          check_field("token_length", tok_if.token_length, want.tok.length);
          check_field("line_number", tok_if.line_number, want.tok.line);
          check_field("last_of_run", 32'(tok_if.last_of_run), 32'(want.last));
        end
      end
    end
  end

  // Run watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  int src_pct[PHASES]  = '{0, 84, 0, 27, 0};
  int sink_pct[PHASES] = '{0, 0, 84, 27, 0};

  initial begin
    char_if.valid       = 1'b0;
    char_if.char_code   = '0;
    char_if.end_of_text = 1'b0;
    tok_if.ready        = 1'b0;
    rst_ni              = 1'b0;
    lexer_reset();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < PHASES; ph++) begin
      src_idle_pct   = src_pct[ph];
      sink_stall_pct = sink_pct[ph];
      if (ph == 0) begin
        // keyword, number-then-dot with three results, lone slash at end of text
        push_str("if 7.;/");
        push_eot();
        // double equals, NUL and top byte, unterminated string
        push_str("==");
        push_byte(8'h00);
        push_byte(8'hff);
        push_str("\"q");
        push_eot();
        // comment and newline, assign at end of text
        push_str("x//\n=");
        push_eot();
        // single-character operators, dangling dot at end of text
        push_str("+-*<>{}9.");
        push_eot();
      end
      gen_text(90);
      while (feed_q.size() != 0) @(posedge clk_i);
    end

    while (feed_q.size() != 0 || char_if.valid) @(posedge clk_i);
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    while (token_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
